>>> rtl/c2p_pkg.sv
// ----------------------------------------------------------------------------
// c2p_pkg: shared types and constants for the Cartesian to polar converter
// Step counts, fixed-point constants, the arctangent table and the beat
// formats handed along the cell chain.
// ----------------------------------------------------------------------------
package c2p_pkg;

    // CORDIC micro-rotations; the table only covers 24
    localparam int ITERATIONS   = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_N     = (ITERATIONS < ATAN_ENTRIES) ? ITERATIONS : ATAN_ENTRIES;
    // square root of a 32-bit radicand: two radicand bits per step
    localparam int SQRT_N       = 16;
    localparam int NUM_CELLS    = (CORDIC_N > SQRT_N) ? CORDIC_N : SQRT_N;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] CORDIC_STEPS = STEP_W'(CORDIC_N);
    localparam logic [STEP_W-1:0] SQRT_STEPS   = STEP_W'(SQRT_N);

    // angle in 2^-16 degree
    localparam logic signed [23:0] Z_MAX      = 24'(90 * 65536);
    localparam logic [24:0]        DEG_180    = 25'(180 * 65536);
    localparam logic [24:0]        DEG_360    = 25'(360 * 65536);
    localparam logic [24:0]        ROUND_HALF = 25'(512);
    localparam logic [14:0]        ANG_WRAP   = 15'(23040);
    localparam logic [15:0]        MAG_MAX    = 16'(46341);

    typedef struct packed {
        logic x_neg;
        logic y_neg;
        logic ax_zero;
        logic ay_zero;
    } c2p_flags_t;

    typedef struct packed {
        logic [15:0] ax;
        logic [15:0] ay;
        logic [30:0] sq_x;
        logic [30:0] sq_y;
        c2p_flags_t  flags;
    } c2p_front_t;

    typedef struct packed {
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic signed [23:0] z;
        logic [31:0]        sq;     // radicand bits still to consume, MSB first
        logic [15:0]        root;
        logic [16:0]        rem;
        c2p_flags_t         flags;
    } c2p_cell_t;

    // atan(2^-i) in degrees, 2^-16 degree units, rounded
    function automatic logic [21:0] atan_q16(input logic [STEP_W-1:0] idx);
        logic [21:0] val;
        unique case (idx)
            5'd0:  val = 22'd2949120;
            5'd1:  val = 22'd1740967;
            5'd2:  val = 22'd919879;
            5'd3:  val = 22'd466945;
            5'd4:  val = 22'd234379;
            5'd5:  val = 22'd117304;
            5'd6:  val = 22'd58666;
            5'd7:  val = 22'd29335;
            5'd8:  val = 22'd14668;
            5'd9:  val = 22'd7334;
            5'd10: val = 22'd3667;
            5'd11: val = 22'd1833;
            5'd12: val = 22'd917;
            5'd13: val = 22'd458;
            5'd14: val = 22'd229;
            5'd15: val = 22'd115;
            5'd16: val = 22'd57;
            5'd17: val = 22'd29;
            5'd18: val = 22'd14;
            5'd19: val = 22'd7;
            5'd20: val = 22'd4;
            5'd21: val = 22'd2;
            5'd22: val = 22'd1;
            default: val = 22'd0;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/c2p_front.sv
// ----------------------------------------------------------------------------
// c2p_front: input stage
// Takes absolute values, quadrant flags and the two squares of a beat.
// ----------------------------------------------------------------------------
module c2p_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic signed [15:0]  in_x,
    input  logic signed [15:0]  in_y,
    output logic                out_valid,
    input  logic                out_ready,
    output c2p_pkg::c2p_front_t out_data
);
    import c2p_pkg::*;

    logic               valid_reg;
    c2p_front_t         data_reg;
    c2p_front_t         data_next;
    logic signed [16:0] xe;
    logic signed [16:0] ye;
    logic signed [31:0] px;
    logic signed [31:0] py;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        xe = 17'(in_x);
        ye = 17'(in_y);
        px = in_x * in_x;
        py = in_y * in_y;
        data_next.ax            = 16'(in_x[15] ? -xe : xe);
        data_next.ay            = 16'(in_y[15] ? -ye : ye);
        data_next.sq_x          = px[30:0];
        data_next.sq_y          = py[30:0];
        data_next.flags.x_neg   = in_x[15];
        data_next.flags.y_neg   = in_y[15];
        data_next.flags.ax_zero = (in_x == 16'sd0);
        data_next.flags.ay_zero = (in_y == 16'sd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

>>> rtl/c2p_cell.sv
// ----------------------------------------------------------------------------
// c2p_cell: one link of the processing chain
// One CORDIC vectoring micro-rotation and one square-root digit per beat.
// ----------------------------------------------------------------------------
module c2p_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic [c2p_pkg::STEP_W-1:0] cell_idx,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  c2p_pkg::c2p_cell_t         in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output c2p_pkg::c2p_cell_t         out_data
);
    import c2p_pkg::*;

    logic               valid_reg;
    c2p_cell_t          data_reg;
    c2p_cell_t          data_next;
    logic signed [33:0] cx;
    logic signed [33:0] cy;
    logic signed [33:0] dx;
    logic signed [33:0] dy;
    logic signed [23:0] atan;
    logic [18:0]        rem_w;
    logic [18:0]        trial;
    logic [18:0]        diff;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        data_next = in_data;
        cx    = in_data.cx;
        cy    = in_data.cy;
        dx    = cy >>> cell_idx;   // floor shift
        dy    = cx >>> cell_idx;
        atan  = signed'({2'b00, atan_q16(cell_idx)});
        rem_w = {in_data.rem, in_data.sq[31:30]};
        trial = {1'b0, in_data.root, 2'b01};
        diff  = rem_w - trial;

        if (cell_idx < CORDIC_STEPS) begin
            if (cy > 34'sd0) begin
                data_next.cx = cx + dx;
                data_next.cy = cy - dy;
                data_next.z  = in_data.z + atan;
            end else begin
                data_next.cx = cx - dx;
                data_next.cy = cy + dy;
                data_next.z  = in_data.z - atan;
            end
        end

        if (cell_idx < SQRT_STEPS) begin
            data_next.sq = {in_data.sq[29:0], 2'b00};
            if (rem_w >= trial) begin
                data_next.rem  = diff[16:0];
                data_next.root = {in_data.root[14:0], 1'b1};
            end else begin
                data_next.rem  = rem_w[16:0];
                data_next.root = {in_data.root[14:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    // partial remainder never exceeds twice the partial root
    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> ({1'b0, data_reg.rem} <= {1'b0, data_reg.root, 1'b0}))
        else $error("c2p_cell: square-root remainder out of range");

endmodule

>>> rtl/c2p_back.sv
// ----------------------------------------------------------------------------
// c2p_back: output stage
// Clamps and places the angle by quadrant, rounds both results, holds the beat.
// ----------------------------------------------------------------------------
module c2p_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  c2p_pkg::c2p_cell_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [15:0]        out_magnitude,
    output logic [14:0]        out_angle
);
    import c2p_pkg::*;

    logic        valid_reg;
    logic [15:0] mag_reg;
    logic [15:0] mag_next;
    logic [14:0] ang_reg;
    logic [14:0] ang_next;
    logic [22:0] phi_c;
    logic [22:0] phi;
    logic [24:0] full;
    logic [24:0] rsum;
    logic [14:0] ang_r;
    logic        y_pos;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        // clamp first-quadrant angle to [0, 90 deg]
        priority if (in_data.z < 24'sd0) begin
            phi_c = 23'd0;
        end else if (in_data.z > Z_MAX) begin
            phi_c = Z_MAX[22:0];
        end else begin
            phi_c = in_data.z[22:0];
        end

        // on an axis the angle is exact
        priority if (in_data.flags.ay_zero) begin
            phi = 23'd0;
        end else if (in_data.flags.ax_zero) begin
            phi = Z_MAX[22:0];
        end else begin
            phi = phi_c;
        end

        y_pos = !in_data.flags.y_neg && !in_data.flags.ay_zero;
        priority if (y_pos) begin
            full = in_data.flags.x_neg ? (DEG_180 - 25'(phi)) : 25'(phi);
        end else if (in_data.flags.x_neg) begin
            full = DEG_180 + 25'(phi);
        end else if (in_data.flags.y_neg) begin
            full = DEG_360 - 25'(phi);
        end else begin
            full = 25'd0;
        end

        rsum  = full + ROUND_HALF;
        ang_r = rsum[24:10];
        ang_next = (ang_r >= ANG_WRAP) ? (ang_r - ANG_WRAP) : ang_r;

        mag_next = in_data.root + 16'({1'b0, in_data.root} < in_data.rem);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            mag_reg <= mag_next;
            ang_reg <= ang_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_magnitude = mag_reg;
    assign out_angle     = ang_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (ang_reg < ANG_WRAP))
        else $error("c2p_back: angle not wrapped below a full turn");

    assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (mag_reg <= MAG_MAX))
        else $error("c2p_back: magnitude beyond largest possible distance");

endmodule

>>> rtl/cartesian_to_polar.sv
// ----------------------------------------------------------------------------
// cartesian_to_polar: pipelined Cartesian to polar converter
// Signed 16-bit (x, y) in; rounded magnitude and angle in 1/64 degree out.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat  : s_x_coord, s_y_coord (signed) with s_valid / s_ready.
//   Output beat : m_magnitude = round(sqrt(x^2 + y^2)), m_angle_deg in
//                 [0, 23040) counting 1/64 degree counter-clockwise from +x,
//                 with m_valid / m_ready.
//   Stages      : one input stage, one cell per CORDIC micro-rotation / root
//                 digit pair, one output stage.
//   Throughput  : one beat per cycle while m_ready stays high. Every stage is a
//                 register with its own valid bit, so a new beat enters
//                 whenever the stage behind it is empty or moving.
//   Stall       : when m_ready is low the held result stays put and beats
//                 queue up in empty stages; s_ready only drops once every
//                 stage is full.
//   Reset       : aresetn (synchronous, active low) empties all stages;
//                 there is no other state.
// ----------------------------------------------------------------------------
module cartesian_to_polar (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_x_coord,
    input  logic signed [15:0] s_y_coord,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [15:0]        m_magnitude,
    output logic [14:0]        m_angle_deg
);
    import c2p_pkg::*;

    // front stage to chain
    logic       front_valid;
    logic       front_ready;
    c2p_front_t front_data;
    c2p_cell_t  seed_data;

    // chain links: index k feeds cell k, index NUM_CELLS feeds the back stage
    logic      link_valid [NUM_CELLS+1];
    logic      link_ready [NUM_CELLS+1];
    c2p_cell_t link_data  [NUM_CELLS+1];

    c2p_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_x      (s_x_coord),
        .in_y      (s_y_coord),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    // seed the chain: CORDIC starts at (|x|, |y|) * 2^16, the square root from the
    // full sum of squares
    always_comb begin
        seed_data.cx    = signed'({2'b00, front_data.ax, 16'd0});
        seed_data.cy    = signed'({2'b00, front_data.ay, 16'd0});
        seed_data.z     = 24'sd0;
        seed_data.sq    = 32'(front_data.sq_x) + 32'(front_data.sq_y);
        seed_data.root  = 16'd0;
        seed_data.rem   = 17'd0;
        seed_data.flags = front_data.flags;
    end
    assign link_data[0]  = seed_data;
    assign link_valid[0] = front_valid;
    assign front_ready   = link_ready[0];

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        c2p_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cell_idx  (STEP_W'(k)),
            .in_valid  (link_valid[k]),
            .in_ready  (link_ready[k]),
            .in_data   (link_data[k]),
            .out_valid (link_valid[k+1]),
            .out_ready (link_ready[k+1]),
            .out_data  (link_data[k+1])
        );
    end

    c2p_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (link_valid[NUM_CELLS]),
        .in_ready      (link_ready[NUM_CELLS]),
        .in_data       (link_data[NUM_CELLS]),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_magnitude (m_magnitude),
        .out_angle     (m_angle_deg)
    );

    // a ready sink lets every stage move, so the input is always open
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("cartesian_to_polar: input blocked while output drains");

endmodule
